@@ rtl/gda_pkg.sv @@
// Shared types, constants and table functions for the Gregorian date arithmetic block.
// Used by gda_ctl, gda_ser, gda_cal and gregorian_date_day_arithmetic. No dependencies.
package gda_pkg;

  // Number of register stages from the input to the output register.
  localparam int NUM_STG = 9;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_SPAN = 1'b1;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DATE  = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  localparam logic [21:0] LAST_SERIAL = 22'd3652058;
  localparam logic [21:0] MARCH_OFS   = 22'd306;
  localparam logic [21:0] ERA_DAYS    = 22'd146097;

  // Reciprocals for division by constants: x / d == (x * R) >> S over the used range.
  localparam logic [13:0] RECIP_100  = 14'd10486;   // shift 20, exact below 43690
  localparam logic [16:0] RECIP_1460 = 17'd91930;   // shift 27, exact below 1864135
  localparam logic [17:0] RECIP_365  = 18'd183860;  // shift 26, exact below 1864135

  typedef struct packed {
    logic [NUM_STG-1:0] ld;   // stage loads at this edge
    logic [NUM_STG-1:0] vld;  // stage holds a word
  } pipe_t;

  // Days before the start of each month of a year that begins in March.
  function automatic logic [8:0] mon_ofs(input logic [3:0] mp);
    logic [8:0] ofs;
    unique case (mp)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

  // Length of a calendar month, January is 1.
  function automatic logic [4:0] mon_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/gregorian_date_day_arithmetic.sv @@
// Gregorian date arithmetic through serial day numbers: adds a day offset or counts days.
// Depends on gda_pkg and instantiates gda_ctl, gda_ser (twice) and gda_cal.
//
// Usage:
//   The input channel (in_valid, in_ready) takes one word per cycle while in_ready is
//   high: a command, a start date, a second date and a signed day offset. Command add
//   returns the start date moved by the offset; command span returns the second date
//   minus the start date plus one. The result channel (out_valid, out_ready) returns
//   exactly one word per input word, in order. An invalid start date, or for span an
//   invalid second date, gives error code 1; an added date outside years 1 to 9999
//   gives error code 2; in both cases all other result fields are zero.
//   Latency: nine register stages. Throughput: one word per cycle while out_ready is
//   high; the stage count is set by the chain date check, serial conversion, add, era
//   division in two halves, the two reciprocal multiplies for the year, the day of the
//   year and the month lookup, each in a stage of its own.
//   When the receiver holds out_ready low, the words stay in their stages; in_ready stays
//   high while any stage is empty, so the pipeline fills up before it stops accepting.
//   Synchronous reset (rst_n low) empties every stage; words still in flight are dropped.
module gregorian_date_day_arithmetic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [4:0]         in_start_day,
  input  logic [3:0]         in_start_month,
  input  logic [13:0]        in_start_year,
  input  logic [4:0]         in_end_day,
  input  logic [3:0]         in_end_month,
  input  logic [13:0]        in_end_year,
  input  logic signed [20:0] in_day_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_result_day,
  output logic [3:0]         out_result_month,
  output logic [13:0]        out_result_year,
  output logic signed [22:0] out_day_count,
  output logic [1:0]         out_error_code
);
  import gda_pkg::*;

  typedef struct packed {
    logic        cmd;
    logic [20:0] off;
  } head_t;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  err;
    logic [22:0] cnt;
  } side_t;

  pipe_t       pipe;
  logic        ok_s;
  logic        ok_e;
  logic [21:0] ser_s;
  logic [21:0] ser_e;
  head_t       head_r [0:1];
  side_t       side_r [2:NUM_STG-1];
  side_t       side_nxt;
  logic [21:0] sum_r;
  logic [23:0] sum_full;
  logic [23:0] cnt_full;
  logic        oor;
  logic [4:0]  cal_day;
  logic [3:0]  cal_month;
  logic [13:0] cal_year;
  logic        show_date;
  logic        show_cnt;

  gda_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .pipe      (pipe)
  );

  gda_ser u_ser_start (
    .clk    (clk),
    .ld     (pipe.ld[1:0]),
    .day    (in_start_day),
    .month  (in_start_month),
    .year   (in_start_year),
    .ok     (ok_s),
    .serial (ser_s)
  );

  gda_ser u_ser_end (
    .clk    (clk),
    .ld     (pipe.ld[1:0]),
    .day    (in_end_day),
    .month  (in_end_month),
    .year   (in_end_year),
    .ok     (ok_e),
    .serial (ser_e)
  );

  always_ff @(posedge clk) begin
    if (pipe.ld[0]) begin
      head_r[0] <= '{cmd: in_cmd, off: in_day_offset};
    end
    if (pipe.ld[1]) begin
      head_r[1] <= head_r[0];
    end
  end

  // Add the offset or take the difference, and settle the error code.
  always_comb begin
    sum_full = {2'b00, ser_s} + {{3{head_r[1].off[20]}}, head_r[1].off};
    cnt_full = {2'b00, ser_e} - {2'b00, ser_s} + 24'd1;
    oor      = sum_full[23] || (sum_full[22:0] > {1'b0, LAST_SERIAL});
    side_nxt.cmd = head_r[1].cmd;
    side_nxt.cnt = cnt_full[22:0];
    priority if (!ok_s || ((head_r[1].cmd == CMD_SPAN) && !ok_e)) begin
      side_nxt.err = ERR_DATE;
    end else if ((head_r[1].cmd == CMD_ADD) && oor) begin
      side_nxt.err = ERR_RANGE;
    end else begin
      side_nxt.err = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.ld[2]) begin
      side_r[2] <= side_nxt;
      sum_r     <= sum_full[21:0];
    end
    for (int k = 3; k < NUM_STG; k++) begin
      if (pipe.ld[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  gda_cal u_cal (
    .clk    (clk),
    .ld     (pipe.ld[NUM_STG-1:3]),
    .serial (sum_r),
    .day    (cal_day),
    .month  (cal_month),
    .year   (cal_year)
  );

  assign show_date = (side_r[NUM_STG-1].err == ERR_NONE) && (side_r[NUM_STG-1].cmd == CMD_ADD);
  assign show_cnt  = (side_r[NUM_STG-1].err == ERR_NONE) && (side_r[NUM_STG-1].cmd == CMD_SPAN);

  assign in_ready         = pipe.ld[0];
  assign out_valid        = pipe.vld[NUM_STG-1];
  assign out_result_day   = show_date ? cal_day : '0;
  assign out_result_month = show_date ? cal_month : '0;
  assign out_result_year  = show_date ? cal_year : '0;
  assign out_day_count    = show_cnt ? $signed(side_r[NUM_STG-1].cnt) : '0;
  assign out_error_code   = side_r[NUM_STG-1].err;

`ifndef SYNTH
  // Any free slot, including one freed by the receiver, lets a new word in.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while the pipeline had room");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> pipe.vld[0])
    else $error("accepted word did not enter the first stage");

  a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_error_code == ERR_NONE) && (out_result_month != '0)) |->
      ((out_result_day != '0) && (out_result_month <= 4'd12) &&
       (out_result_year != '0) && (out_result_year <= 14'd9999)))
    else $error("computed date outside the calendar");
`endif

endmodule

@@ rtl/gda_ctl.sv @@
// Valid and load control for the date pipeline: one valid bit per stage.
// Depends on gda_pkg for NUM_STG and pipe_t.
module gda_ctl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_ready,
  output gda_pkg::pipe_t pipe
);
  import gda_pkg::*;

  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] vld_nxt;
  logic [NUM_STG-1:0] ld_c;

  // A stage may load when it is empty or when the stage after it loads too.
  always_comb begin
    ld_c[NUM_STG-1] = !vld_r[NUM_STG-1] || out_ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      ld_c[k] = !vld_r[k] || ld_c[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = ld_c[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STG; k++) begin
      vld_nxt[k] = ld_c[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign pipe.ld  = ld_c;
  assign pipe.vld = vld_r;

endmodule

@@ rtl/gda_ser.sv @@
// Two-stage date check and conversion of a calendar date to a serial day number.
// Depends on gda_pkg for the month tables and the reciprocal of 100.
module gda_ser (
  input  logic        clk,
  input  logic [1:0]  ld,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [13:0] year,
  output logic        ok,
  output logic [21:0] serial
);
  import gda_pkg::*;

  logic [27:0] prod;
  logic [7:0]  q;
  logic [13:0] rem;
  logic        leap;
  logic        early;
  logic [3:0]  mp;
  logic        ok_nxt;
  logic [13:0] ya_nxt;
  logic [7:0]  qa_nxt;
  logic [8:0]  doy_nxt;

  logic        ok_a_r;
  logic [13:0] ya_r;
  logic [7:0]  qa_r;
  logic [8:0]  doy_r;

  logic [22:0] acc;
  logic        ok_r;
  logic [21:0] serial_r;
  logic [21:0] serial_nxt;

  // Stage A: leap year, validity, March-based year and day of year.
  always_comb begin
    prod  = {14'b0, year} * {14'b0, RECIP_100};
    q     = prod[27:20];
    rem   = year - ({6'b0, q} * 14'd100);
    leap  = (year[1:0] == 2'b00) && ((rem != '0) || (q[1:0] == 2'b00));
    ok_nxt = (year != '0) && (year <= 14'd9999) && (month != '0) && (month <= 4'd12) &&
             (day != '0) && (day <= mon_len(month, leap));
    early = (month <= 4'd2);
    // January and February count toward the previous year.
    ya_nxt  = early ? year - 14'd1 : year;
    qa_nxt  = (early && (rem == '0)) ? q - 8'd1 : q;
    mp      = early ? month + 4'd9 : month - 4'd3;
    doy_nxt = mon_ofs(mp) + {4'b0, day} - 9'd1;
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      ok_a_r <= ok_nxt;
      ya_r   <= ya_nxt;
      qa_r   <= qa_nxt;
      doy_r  <= doy_nxt;
    end
  end

  // Stage B: 365 days a year plus the leap days up to the year, plus the day of year.
  always_comb begin
    acc = ({9'b0, ya_r} * 23'd365) + {11'b0, ya_r[13:2]} - {15'b0, qa_r} +
          {17'b0, qa_r[7:2]} + {14'b0, doy_r} - {1'b0, MARCH_OFS};
    serial_nxt = acc[21:0];
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      ok_r     <= ok_a_r;
      serial_r <= serial_nxt;
    end
  end

  assign ok     = ok_r;
  assign serial = serial_r;

endmodule

@@ rtl/gda_cal.sv @@
// Six-stage conversion of a serial day number back to a calendar date.
// Depends on gda_pkg for the era length, the reciprocals and the month offsets.
module gda_cal (
  input  logic        clk,
  input  logic [5:0]  ld,
  input  logic [21:0] serial,
  output logic [4:0]  day,
  output logic [3:0]  month,
  output logic [13:0] year
);
  import gda_pkg::*;

  // Stage 1: upper three bits of the 400-year era by restoring division.
  logic [21:0] rem1;
  logic [4:0]  era1;
  logic [21:0] rem1_r;
  logic [4:0]  era1_r;

  always_comb begin
    rem1 = serial + MARCH_OFS;
    era1 = '0;
    for (int k = 4; k >= 2; k--) begin
      if (rem1 >= (ERA_DAYS << k)) begin
        rem1    = rem1 - (ERA_DAYS << k);
        era1[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      rem1_r <= rem1;
      era1_r <= era1;
    end
  end

  // Stage 2: lower two era bits; the remainder is the day of the era.
  logic [21:0] rem2;
  logic [4:0]  era2;
  logic [17:0] doe2_r;
  logic [4:0]  era2_r;

  always_comb begin
    rem2 = rem1_r;
    era2 = era1_r;
    for (int k = 1; k >= 0; k--) begin
      if (rem2 >= (ERA_DAYS << k)) begin
        rem2    = rem2 - (ERA_DAYS << k);
        era2[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      doe2_r <= rem2[17:0];
      era2_r <= era2;
    end
  end

  // Stage 3: remove the leap days so that a plain division by 365 gives the year.
  logic [34:0] p3;
  logic [7:0]  a3;
  logic [2:0]  b3;
  logic        c3;
  logic [17:0] t3_nxt;
  logic [17:0] t3_r;
  logic [17:0] doe3_r;
  logic [4:0]  era3_r;

  always_comb begin
    p3 = {17'b0, doe2_r} * {18'b0, RECIP_1460};
    a3 = p3[34:27];
    b3 = {2'b0, doe2_r >= 18'd36524} + {2'b0, doe2_r >= 18'd73048} +
         {2'b0, doe2_r >= 18'd109572} + {2'b0, doe2_r >= 18'd146096};
    c3 = (doe2_r == 18'd146096);
    t3_nxt = doe2_r - {10'b0, a3} + {15'b0, b3} - {17'b0, c3};
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      t3_r   <= t3_nxt;
      doe3_r <= doe2_r;
      era3_r <= era2_r;
    end
  end

  // Stage 4: year of the era.
  logic [35:0] p4;
  logic [8:0]  yoe4_r;
  logic [17:0] doe4_r;
  logic [4:0]  era4_r;

  always_comb begin
    p4 = {18'b0, t3_r} * {18'b0, RECIP_365};
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      yoe4_r <= p4[34:26];
      doe4_r <= doe3_r;
      era4_r <= era3_r;
    end
  end

  // Stage 5: day of the March-based year.
  logic [1:0]  yc5;
  logic [17:0] base5;
  logic [17:0] doy5;
  logic [8:0]  doy5_r;
  logic [8:0]  yoe5_r;
  logic [4:0]  era5_r;

  always_comb begin
    yc5 = {1'b0, yoe4_r >= 9'd100} + {1'b0, yoe4_r >= 9'd200} + {1'b0, yoe4_r >= 9'd300};
    base5 = ({9'b0, yoe4_r} * 18'd365) + {11'b0, yoe4_r[8:2]} - {16'b0, yc5};
    doy5  = doe4_r - base5;
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      doy5_r <= doy5[8:0];
      yoe5_r <= yoe4_r;
      era5_r <= era4_r;
    end
  end

  // Stage 6: month by comparing against the month offsets, then day and year.
  logic [3:0]  mp6;
  logic [8:0]  dd6;
  logic [3:0]  mon6;
  logic [13:0] year6;
  logic [4:0]  day_r;
  logic [3:0]  month_r;
  logic [13:0] year_r;

  always_comb begin
    mp6 = '0;
    for (int i = 1; i < 12; i++) begin
      mp6 = mp6 + {3'b0, doy5_r >= mon_ofs(4'(i))};
    end
    dd6  = doy5_r - mon_ofs(mp6) + 9'd1;
    mon6 = (mp6 < 4'd10) ? mp6 + 4'd3 : mp6 - 4'd9;
    // January and February belong to the following calendar year.
    year6 = {5'b0, yoe5_r} + ({9'b0, era5_r} * 14'd400) + {13'b0, mp6 >= 4'd10};
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      day_r   <= dd6[4:0];
      month_r <= mon6;
      year_r  <= year6;
    end
  end

  assign day   = day_r;
  assign month = month_r;
  assign year  = year_r;

endmodule

@@ verif/gda_tb_pkg.sv @@
// Word types and the result board for the Gregorian date arithmetic testbench.
// The board predicts each result from its own calendar arithmetic and checks the DUT output.
// Depends on gda_pkg for the command and error codes and the last serial day.
package gda_tb_pkg;

  import gda_pkg::*;

  typedef struct packed {
    logic               cmd;
    logic [4:0]         start_day;
    logic [3:0]         start_month;
    logic [13:0]        start_year;
    logic [4:0]         end_day;
    logic [3:0]         end_month;
    logic [13:0]        end_year;
    logic signed [20:0] day_offset;
  } date_req_t;

  typedef struct packed {
    logic [4:0]         day;
    logic [3:0]         month;
    logic [13:0]        year;
    logic signed [22:0] count;
    logic [1:0]         err;
  } date_res_t;

  class gda_result_board;
    date_res_t expected_q[$];
    int        fail_count;
    int        word_count;
    int        move_count;
    int        span_count;
    int        bad_date_count;
    int        range_count;

    function bit is_leap(int y);
      return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function bit date_ok(int d, int m, int y);
      int len;
      if (y < 1 || y > 9999 || m < 1 || m > 12) return 1'b0;
      case (m)
        2:             len = is_leap(y) ? 29 : 28;
        4, 6, 9, 11:   len = 30;
        default:       len = 31;
      endcase
      return d >= 1 && d <= len;
    endfunction

    // Days since 0001-01-01, counting years from March so that the leap day falls last.
    function int day_number(int d, int m, int y);
      int ya, era, yoe, mp, doy, doe;
      ya  = (m <= 2) ? y - 1 : y;
      era = ya / 400;
      yoe = ya - era * 400;
      mp  = (m + 9) % 12;
      doy = (153 * mp + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 306;
    endfunction

    function void day_to_date(int s, output int d, output int m, output int y);
      int z, era, doe, yoe, doy, mp;
      z   = s + 306;
      era = z / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      d   = doy - (153 * mp + 2) / 5 + 1;
      m   = (mp < 10) ? mp + 3 : mp - 9;
      y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
    endfunction

    function date_res_t predict_result(date_req_t r);
      date_res_t res;
      int        first, moved, d, m, y;
      res = '0;
      if (!date_ok(r.start_day, r.start_month, r.start_year) ||
          (r.cmd == CMD_SPAN && !date_ok(r.end_day, r.end_month, r.end_year))) begin
        res.err = ERR_DATE;
        return res;
      end
      first = day_number(r.start_day, r.start_month, r.start_year);
      if (r.cmd == CMD_ADD) begin
        moved = first + int'($signed(r.day_offset));
        if (moved < 0 || moved > int'(LAST_SERIAL)) begin
          res.err = ERR_RANGE;
        end else begin
          day_to_date(moved, d, m, y);
          res.day   = 5'(d);
          res.month = 4'(m);
          res.year  = 14'(y);
        end
      end else begin
        res.count = 23'(day_number(r.end_day, r.end_month, r.end_year) - first + 1);
      end
      return res;
    endfunction

    function void note_request(date_req_t r);
      date_res_t res;
      res = predict_result(r);
      expected_q.push_back(res);
      word_count++;
      if (res.err == ERR_DATE) bad_date_count++;
      else if (res.err == ERR_RANGE) range_count++;
      else if (r.cmd == CMD_ADD) move_count++;
      else span_count++;
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(date_res_t got);
      date_res_t want;
      if (expected_q.size() == 0) begin
        $error("result word with no request outstanding");
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("result_day", want.day, got.day);
      compare_field("result_month", want.month, got.month);
      compare_field("result_year", want.year, got.year);
      compare_field("day_count", longint'(want.count), longint'(got.count));
      compare_field("error_code", want.err, got.err);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

@@ verif/tb_gregorian_date_day_arithmetic.sv @@
// Top-level testbench for gregorian_date_day_arithmetic: directed and random words under idling.
// Depends on gda_pkg, gda_tb_pkg and the RTL of the block.
module tb_gregorian_date_day_arithmetic;

  timeunit 1ns;
  timeprecision 1ps;

  import gda_pkg::*;
  import gda_tb_pkg::*;

  localparam int RUN_LIMIT    = 200000;
  localparam int RANDOM_WORDS = 760;
  localparam int NUM_PHASES   = 4;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_cmd         = CMD_ADD;
  logic [4:0]         in_start_day   = '0;
  logic [3:0]         in_start_month = '0;
  logic [13:0]        in_start_year  = '0;
  logic [4:0]         in_end_day     = '0;
  logic [3:0]         in_end_month   = '0;
  logic [13:0]        in_end_year    = '0;
  logic signed [20:0] in_day_offset  = '0;
  logic               out_ready      = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [4:0]         out_result_day;
  logic [3:0]         out_result_month;
  logic [13:0]        out_result_year;
  logic signed [22:0] out_day_count;
  logic [1:0]         out_error_code;

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int cycle_count     = 0;

  gda_result_board board = new;

  gregorian_date_day_arithmetic i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_start_day     (in_start_day),
    .in_start_month   (in_start_month),
    .in_start_year    (in_start_year),
    .in_end_day       (in_end_day),
    .in_end_month     (in_end_month),
    .in_end_year      (in_end_year),
    .in_day_offset    (in_day_offset),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_day   (out_result_day),
    .out_result_month (out_result_month),
    .out_result_year  (out_result_year),
    .out_day_count    (out_day_count),
    .out_error_code   (out_error_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : result_monitor
    date_res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.day   = out_result_day;
      got.month = out_result_month;
      got.year  = out_result_year;
      got.count = out_day_count;
      got.err   = out_error_code;
      board.check_result(got);
    end
  end

  function automatic date_req_t date_request(logic cmd, int sd, int sm, int sy,
                                             int ed, int em, int ey, int offset);
    date_req_t r;
    r.cmd         = cmd;
    r.start_day   = 5'(sd);
    r.start_month = 4'(sm);
    r.start_year  = 14'(sy);
    r.end_day     = 5'(ed);
    r.end_month   = 4'(em);
    r.end_year    = 14'(ey);
    r.day_offset  = 21'(offset);
    return r;
  endfunction

  // Years near both ends of the calendar are favored so that moves run off its edges.
  function automatic void random_date(output logic [4:0] d, output logic [3:0] m,
                                      output logic [13:0] y);
    int yy, mm, dd;
    if ($urandom_range(7) == 0) begin
      yy = $urandom_range(1) ? $urandom_range(1, 3) : $urandom_range(9997, 9999);
    end else begin
      yy = $urandom_range(1, 9999);
    end
    mm = $urandom_range(1, 12);
    do begin
      dd = $urandom_range(1, 31);
    end while (!board.date_ok(dd, mm, yy));
    d = 5'(dd);
    m = 4'(mm);
    y = 14'(yy);
  endfunction

  function automatic date_req_t random_request();
    date_req_t r;
    r.cmd        = 1'($urandom_range(1));
    r.day_offset = 21'($urandom);
    if ($urandom_range(99) < 80) begin
      random_date(r.start_day, r.start_month, r.start_year);
      random_date(r.end_day, r.end_month, r.end_year);
      case ($urandom_range(3))
        0:       r.day_offset = 21'(int'($urandom_range(2000)) - 1000);
        1:       r.day_offset = 21'(int'($urandom_range(800000)) - 400000);
        default: ;
      endcase
    end else begin
      r.start_day   = 5'($urandom);
      r.start_month = 4'($urandom);
      r.start_year  = $urandom_range(1) ? 14'($urandom) : 14'($urandom_range(1, 9999));
      r.end_day     = 5'($urandom);
      r.end_month   = 4'($urandom);
      r.end_year    = 14'($urandom);
    end
    return r;
  endfunction

  // Valid is only lowered for an idle gap, never between two back-to-back words.
  task automatic send_request(input date_req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= r.cmd;
    in_start_day   <= r.start_day;
    in_start_month <= r.start_month;
    in_start_year  <= r.start_year;
    in_end_day     <= r.end_day;
    in_end_month   <= r.end_month;
    in_end_year    <= r.end_year;
    in_day_offset  <= r.day_offset;
    do begin
      @(posedge clk);
    end while (!in_ready);
    board.note_request(r);
  endtask

  initial begin
    date_req_t directed_q[$];

    directed_q.push_back(date_request(CMD_ADD, 1, 1, 1, 1, 1, 1, 0));
    directed_q.push_back(date_request(CMD_ADD, 1, 1, 1, 1, 1, 1, -1));
    directed_q.push_back(date_request(CMD_ADD, 31, 12, 9999, 1, 1, 1, 1));
    directed_q.push_back(date_request(CMD_ADD, 31, 12, 9999, 1, 1, 1, -3652058));
    directed_q.push_back(date_request(CMD_ADD, 1, 1, 2000, 1, 1, 1, 1048575));
    directed_q.push_back(date_request(CMD_ADD, 15, 6, 5000, 1, 1, 1, -1048576));
    directed_q.push_back(date_request(CMD_ADD, 28, 2, 2024, 1, 1, 1, 1));
    directed_q.push_back(date_request(CMD_ADD, 28, 2, 1900, 1, 1, 1, 1));
    directed_q.push_back(date_request(CMD_ADD, 29, 2, 2000, 1, 1, 1, 365));
    directed_q.push_back(date_request(CMD_SPAN, 1, 1, 1, 31, 12, 9999, 0));
    directed_q.push_back(date_request(CMD_SPAN, 31, 12, 9999, 1, 1, 1, 0));
    directed_q.push_back(date_request(CMD_SPAN, 15, 3, 2024, 15, 3, 2024, 0));
    directed_q.push_back(date_request(CMD_SPAN, 29, 2, 1600, 29, 2, 2000, 0));
    // Invalid start dates: zero and overlong days, bad months, bad years, false leap days.
    directed_q.push_back(date_request(CMD_ADD, 0, 5, 2020, 1, 1, 1, 3));
    directed_q.push_back(date_request(CMD_ADD, 31, 4, 2023, 1, 1, 1, 3));
    directed_q.push_back(date_request(CMD_ADD, 10, 0, 2020, 1, 1, 1, 3));
    directed_q.push_back(date_request(CMD_ADD, 10, 13, 2020, 1, 1, 1, 3));
    directed_q.push_back(date_request(CMD_ADD, 31, 15, 16383, 31, 15, 16383, -1));
    directed_q.push_back(date_request(CMD_ADD, 10, 6, 0, 1, 1, 1, 3));
    directed_q.push_back(date_request(CMD_ADD, 29, 2, 1900, 1, 1, 1, 0));
    directed_q.push_back(date_request(CMD_ADD, 29, 2, 2100, 1, 1, 1, 0));
    directed_q.push_back(date_request(CMD_ADD, 30, 2, 2024, 1, 1, 1, 0));
    // The second date matters only to the day count.
    directed_q.push_back(date_request(CMD_SPAN, 1, 1, 2021, 29, 2, 2021, 0));
    directed_q.push_back(date_request(CMD_ADD, 1, 1, 2021, 31, 15, 16383, 10));
    directed_q.push_back(date_request(CMD_SPAN, 1, 13, 2021, 1, 1, 2021, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i]) send_request(directed_q[i]);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       begin sender_idle_pct <= 0;  stall_pct <= 0;  end
        1:       begin sender_idle_pct <= 47; stall_pct <= 0;  end
        2:       begin sender_idle_pct <= 0;  stall_pct <= 47; end
        default: begin sender_idle_pct <= 21; stall_pct <= 21; end
      endcase
      repeat (RANDOM_WORDS / NUM_PHASES) send_request(random_request());
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (NUM_STG + 4) @(posedge clk);

    $display("Checked %0d words: %0d date moves and %0d day counts in range,",
             board.word_count, board.move_count, board.span_count);
    $display("%0d invalid dates and %0d moves past the calendar edges, under four idling mixes.",
             board.bad_date_count, board.range_count);
    if (board.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
